/* rtl/core/lnps_pkg.sv */
// ----------------------------------------------------------------------------
// lnps_pkg: shared definitions of the last-note-priority stack
// Constants, codes and the command and status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package lnps_pkg;

  localparam int STACK_DEPTH_DEF = 8;
  localparam int NOTE_W          = 7;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 4;

  localparam logic [7:0]        STATUS_NOTE_ON = 8'h90;
  localparam logic [NOTE_W-1:0] VEL_ON         = 7'd127;
  localparam logic [NOTE_W-1:0] VEL_OFF        = 7'd0;

  // Request kinds.
  localparam logic CMD_PRESS   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CHANNEL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ENABLE  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the request fields
    logic search;    // register the match vector
    logic update;    // apply the stack change
    logic send_off;  // drive the key-off message
    logic send_on;   // drive the key-on message
  } lnps_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_off;     // valid during the update step
    logic has_on;      // valid during the update step
    logic on_pending;  // a key-on follows the key-off
  } lnps_status_t;

endpackage

/* rtl/core/lnps_ctrl.sv */
// ----------------------------------------------------------------------------
// lnps_ctrl: request sequencer
// Walks each request through search, update and up to two message steps.
// ----------------------------------------------------------------------------
module lnps_ctrl import lnps_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  output lnps_cmd_t    cmd,
  input  lnps_status_t status
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE,
    ST_EMIT_OFF,
    ST_EMIT_ON
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
        state_nxt  = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        if (status.has_off) begin
          state_nxt = ST_EMIT_OFF;
        end else if (status.has_on) begin
          state_nxt = ST_EMIT_ON;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT_OFF: begin
        cmd.send_off = 1'b1;
        state_nxt    = status.on_pending ? ST_EMIT_ON : ST_IDLE;
      end
      ST_EMIT_ON: begin
        cmd.send_on = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  a_accept_to_search: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == ST_SEARCH))
    else $error("accepted request did not enter search");

  a_emit_on_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT_ON) |-> ($past(state_r) == ST_UPDATE || $past(state_r) == ST_EMIT_OFF))
    else $error("key-on step entered from a wrong step");

  a_single_off: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.send_off |=> !cmd.send_off)
    else $error("two key-off steps in a row");

endmodule

/* rtl/core/lnps_datapath.sv */
// ----------------------------------------------------------------------------
// lnps_datapath: note stack, configuration and message registers
// The stack is a row of registers with the sounding note at entry 0.
// ----------------------------------------------------------------------------
module lnps_datapath import lnps_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF,
  localparam int CNT_W = $clog2(STACK_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lnps_cmd_t             cmd,
  output lnps_status_t          status,
  input  logic                  in_command,
  input  logic [NOTE_W-1:0]     in_note,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_valid,
  output logic [7:0]            out_status_byte,
  output logic [NOTE_W-1:0]     out_note_number,
  output logic [NOTE_W-1:0]     out_velocity,
  output logic                  out_last
);

  localparam logic [STACK_DEPTH-1:0] ONES = {STACK_DEPTH{1'b1}};

  logic [3:0]             channel_r;
  logic                   enable_r;
  logic                   cmd_r;
  logic [NOTE_W-1:0]      note_r;
  logic [NOTE_W-1:0]      stack_r   [STACK_DEPTH];
  logic [NOTE_W-1:0]      stack_nxt [STACK_DEPTH];
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [STACK_DEPTH-1:0] match_r, match_nxt;
  logic [STACK_DEPTH-1:0] shift_mask;
  logic                   any_match;
  logic                   has_off_c, has_on_c, has_on_r;
  logic [NOTE_W-1:0]      off_note_c, on_note_c, off_note_r, on_note_r;
  logic                   out_valid_r, out_last_r;
  logic [7:0]             out_status_r;
  logic [NOTE_W-1:0]      out_note_r, out_vel_r;

  // One comparator per entry; only entries below the fill count take part.
  always_comb begin
    for (int i = 0; i < STACK_DEPTH; i++) begin
      match_nxt[i] = (stack_r[i] == note_r) && (CNT_W'(i) < count_r);
    end
  end

  // Entries at or below the matching one move up by one place on removal.
  // Notes in the stack are unique, so at most one match bit is set.
  always_comb begin
    for (int i = 0; i < STACK_DEPTH; i++) begin
      shift_mask[i] = |(match_r & (ONES >> (STACK_DEPTH - 1 - i)));
    end
  end

  assign any_match = |match_r;

  always_comb begin
    stack_nxt  = stack_r;
    count_nxt  = count_r;
    has_off_c  = 1'b0;
    has_on_c   = 1'b0;
    off_note_c = stack_r[0];
    on_note_c  = note_r;
    if (cmd_r == CMD_PRESS) begin
      if (!any_match) begin
        stack_nxt[0] = note_r;
        for (int i = 1; i < STACK_DEPTH; i++) begin
          stack_nxt[i] = stack_r[i-1];
        end
        if (count_r != CNT_W'(STACK_DEPTH)) begin
          count_nxt = count_r + CNT_W'(1);
        end
        has_off_c = (count_r != '0);
        has_on_c  = 1'b1;
      end
    end else if (any_match) begin
      for (int i = 0; i < STACK_DEPTH; i++) begin
        if (shift_mask[i]) begin
          stack_nxt[i] = stack_r[(i < STACK_DEPTH - 1) ? i + 1 : i];
        end
      end
      count_nxt = count_r - CNT_W'(1);
      if (match_r[0]) begin
        has_off_c  = 1'b1;
        off_note_c = note_r;
        has_on_c   = (count_r > CNT_W'(1));
        on_note_c  = stack_r[1];
      end
    end
  end

  assign status.has_off    = has_off_c & enable_r;
  assign status.has_on     = has_on_c & enable_r;
  assign status.on_pending = has_on_r;

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_r   <= '0;
      enable_r    <= 1'b0;
      count_r     <= '0;
      has_on_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IDX_CHANNEL: channel_r <= cfg_data;
          CFG_IDX_ENABLE:  enable_r  <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (cmd.update) begin
        count_r  <= count_nxt;
        has_on_r <= has_on_c & enable_r;
      end
      out_valid_r <= cmd.send_off | cmd.send_on;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_command;
      note_r <= in_note;
    end
    if (cmd.search) begin
      match_r <= match_nxt;
    end
    if (cmd.update) begin
      stack_r    <= stack_nxt;
      off_note_r <= off_note_c;
      on_note_r  <= on_note_c;
    end
    if (cmd.send_off) begin
      out_status_r <= STATUS_NOTE_ON | {4'b0000, channel_r};
      out_note_r   <= off_note_r;
      out_vel_r    <= VEL_OFF;
      out_last_r   <= !has_on_r;
    end else if (cmd.send_on) begin
      out_status_r <= STATUS_NOTE_ON | {4'b0000, channel_r};
      out_note_r   <= on_note_r;
      out_vel_r    <= VEL_ON;
      out_last_r   <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status_byte = out_status_r;
  assign out_note_number = out_note_r;
  assign out_velocity    = out_vel_r;
  assign out_last        = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(STACK_DEPTH))
    else $error("fill count above stack depth");

  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |=> (out_valid_r && out_last_r))
    else $error("first message of a pair not followed by the final one");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |=> !out_valid_r)
    else $error("message directly after the final message of a request");

endmodule

/* rtl/core/last_note_priority_stack_core.sv */
// ----------------------------------------------------------------------------
// Sequence: each request passes the accepting idle step, search, update,
// then one step per message; a second message follows in the cycle after
// the first. busy stays high until the controller is back in idle, so a new
// request is taken only once the last one is done.
// Reset: synchronous, active low; empties the stack, clears the channel and
// the output enable. The receiver cannot stall the message stream.
// ----------------------------------------------------------------------------
// last_note_priority_stack_core: monophonic last-note-priority voice assigner
// Keeps the held notes in press order and issues key-off/key-on messages
// so that the most recently pressed held note is the one that sounds.
// ----------------------------------------------------------------------------
module last_note_priority_stack_core import lnps_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Request channel: accepted when start is high and busy is low.
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_command,
  input  logic [NOTE_W-1:0]     in_note,
  // Message channel: each message is valid for exactly one cycle.
  output logic                  out_valid,
  output logic [7:0]            out_status_byte,
  output logic [NOTE_W-1:0]     out_note_number,
  output logic [NOTE_W-1:0]     out_velocity,
  output logic                  out_last,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // The controller steps each request through its phases and tells the
  // datapath when to capture, search, update and send. The datapath reports
  // back which messages the request produces, already masked by the output
  // enable, so that the controller skips message steps that send nothing.
  lnps_cmd_t    cmd;
  lnps_status_t status;

  lnps_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  // The stack keeps the sounding note at entry 0. A press shifts every entry
  // down by one, so the oldest note falls off the end when the stack is full.
  // A release shifts the entries below the released note up by one place.
  lnps_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_command      (in_command),
    .in_note         (in_note),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_status_byte (out_status_byte),
    .out_note_number (out_note_number),
    .out_velocity    (out_velocity),
    .out_last        (out_last)
  );

endmodule
